// File: rtl/lcw_format80_decompressor_top_assert.svh
// Assertion macros for the LCW format80 decompressor.
// Used by the port checker; no other dependencies.
`ifndef LCW_FORMAT80_DECOMPRESSOR_TOP_ASSERT_SVH
`define LCW_FORMAT80_DECOMPRESSOR_TOP_ASSERT_SVH

// same-cycle property, disabled in reset
`define LCWF80_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle
`define LCWF80_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lcwf80_pkg.sv
// Shared types and constants for the LCW format80 decompressor.
// No dependencies.
package lcwf80_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned WPOS_W      = 17;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_DRAIN   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_END_OK   = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_BAD_REF  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_pos;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // result leaving the decode stage
  typedef struct packed {
    logic        valid;
    logic        is_copy;
    logic [7:0]  data;
    logic [15:0] pos;
    logic [2:0]  status;
  } res_t;

  // store read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_t;

endpackage

// File: rtl/lcwf80_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lcwf80_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [(2**AW)-1:0];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lcwf80_ctrl.sv
// Command decoder and stream state of the LCW format80 decompressor.
// Depends on lcwf80_pkg.
module lcwf80_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  lcwf80_pkg::in_item_t in_item_i,
  input  logic                 cfg_we_i,
  input  logic [16:0]          cfg_data_i,
  output lcwf80_pkg::res_t     res_o,
  output lcwf80_pkg::rd_t      rd_o
);
  import lcwf80_pkg::*;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_LIT  = 3'd1;
  localparam logic [2:0] KIND_REL  = 3'd2;
  localparam logic [2:0] KIND_ABS  = 3'd3;
  localparam logic [2:0] KIND_FILL = 3'd4;
  localparam logic [2:0] KIND_LONG = 3'd5;

  logic [16:0]       exp_q;
  logic [WPOS_W-1:0] wp_q, wp_d;
  logic [2:0]        stage_q, stage_d;
  logic [2:0]        kind_q, kind_d;
  logic [15:0]       hdr_q, hdr_d;
  logic [15:0]       pend_q, pend_d;
  logic [WPOS_W-1:0] src_q, src_d;
  logic [7:0]        fill_q, fill_d;
  logic              halted_q, halted_d;

  logic [15:0] hb_hdr, hb_pend;
  logic [2:0]  hb_stage;
  logic        put_req, put_copy, fin_req, ovf;
  logic [7:0]  put_val, b;
  logic [2:0]  fin_st;

  assign b   = in_item_i.data_byte;
  assign ovf = (wp_q >= WPOS_W'(STORE_DEPTH));

  // header byte merge
  always_comb begin
    hb_hdr   = hdr_q;
    hb_pend  = pend_q;
    hb_stage = stage_q - 3'd1;
    unique case (kind_q)
      KIND_REL: hb_hdr = {4'd0, hdr_q[3:0], b};
      KIND_ABS: begin
        if (stage_q == 3'd2) hb_hdr[7:0] = hdr_q[7:0] | b;
        else                 hb_hdr[15:8] = hdr_q[15:8] | b;
      end
      KIND_FILL: begin
        if (stage_q == 3'd3)      hb_pend[7:0]  = pend_q[7:0] | b;
        else if (stage_q == 3'd2) hb_pend[15:8] = pend_q[15:8] | b;
        else                      hb_hdr[7:0]   = hdr_q[7:0] | b;
      end
      KIND_LONG: begin
        if (stage_q == 3'd4)      hb_pend[7:0]  = pend_q[7:0] | b;
        else if (stage_q == 3'd3) hb_pend[15:8] = pend_q[15:8] | b;
        else if (stage_q == 3'd2) hb_hdr[7:0]   = hdr_q[7:0] | b;
        else                      hb_hdr[15:8]  = hdr_q[15:8] | b;
      end
      default: ;
    endcase
  end

  always_comb begin
    wp_d     = wp_q;
    stage_d  = stage_q;
    kind_d   = kind_q;
    hdr_d    = hdr_q;
    pend_d   = pend_q;
    src_d    = src_q;
    fill_d   = fill_q;
    halted_d = halted_q;
    res_o    = '0;
    rd_o     = '0;
    put_req  = 1'b0;
    put_copy = 1'b0;
    put_val  = b;
    fin_req  = 1'b0;
    fin_st   = ST_DATA;

    if (accept_i) begin
      unique case (in_item_i.action)
        ACT_RESTART: begin
          wp_d     = '0;
          stage_d  = '0;
          kind_d   = KIND_NONE;
          hdr_d    = '0;
          pend_d   = '0;
          src_d    = '0;
          fill_d   = '0;
          halted_d = 1'b0;
        end
        ACT_DRAIN: begin
          if (!halted_q && kind_q >= KIND_REL && stage_q == 3'd0 && pend_q != 16'd0) begin
            if (ovf) begin
              fin_req = 1'b1;
              fin_st  = ST_OVERFLOW;
            end else if (kind_q == KIND_FILL) begin
              put_req = 1'b1;
              put_val = fill_q;
            end else if (src_q >= wp_q) begin
              fin_req = 1'b1;
              fin_st  = ST_BAD_REF;
            end else begin
              put_req   = 1'b1;
              put_copy  = 1'b1;
              rd_o.en   = 1'b1;
              rd_o.addr = src_q[ADDR_W-1:0];
              src_d     = src_q + WPOS_W'(1);
            end
          end
        end
        ACT_BYTE: begin
          if (!halted_q) begin
            if (kind_q == KIND_LIT) begin
              put_req = 1'b1;
            end else if (kind_q >= KIND_REL && stage_q == 3'd0) begin
              fin_req = 1'b1;
              fin_st  = ST_REFUSED;
            end else if (kind_q >= KIND_REL) begin
              hdr_d   = hb_hdr;
              pend_d  = hb_pend;
              stage_d = hb_stage;
              if (hb_stage == 3'd0) begin
                if (kind_q == KIND_REL)       src_d  = wp_q - {5'd0, hb_hdr[11:0]};
                else if (kind_q == KIND_FILL) fill_d = hb_hdr[7:0];
                else                          src_d  = {1'b0, hb_hdr};
                if (hb_pend == 16'd0) kind_d = KIND_NONE;
              end
            end else if (b[7:6] == 2'b10) begin
              if (b[5:0] == 6'd0) begin
                fin_req = 1'b1;
                fin_st  = (wp_q == exp_q) ? ST_END_OK : ST_MISMATCH;
              end else begin
                kind_d = KIND_LIT;
                pend_d = {10'd0, b[5:0]};
              end
            end else begin
              hdr_d  = '0;
              pend_d = '0;
              if (!b[7]) begin
                kind_d  = KIND_REL;
                pend_d  = 16'({1'b0, b[6:4]} + 4'd3);
                hdr_d   = {12'd0, b[3:0]};
                stage_d = 3'd1;
              end else if (b == 8'hff) begin
                kind_d  = KIND_LONG;
                stage_d = 3'd4;
              end else if (b == 8'hfe) begin
                kind_d  = KIND_FILL;
                stage_d = 3'd3;
              end else begin
                kind_d  = KIND_ABS;
                pend_d  = 16'({1'b0, b[5:0]} + 7'd3);
                stage_d = 3'd2;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (put_req) begin
      if (ovf) begin
        fin_req = 1'b1;
        fin_st  = ST_OVERFLOW;
      end else begin
        wp_d          = wp_q + WPOS_W'(1);
        pend_d        = pend_q - 16'd1;
        if (pend_q == 16'd1) kind_d = KIND_NONE;
        res_o.valid   = 1'b1;
        res_o.is_copy = put_copy;
        res_o.data    = put_val;
        res_o.pos     = wp_q[15:0];
        res_o.status  = ST_DATA;
      end
    end

    if (fin_req) begin
      halted_d      = 1'b1;
      res_o.valid   = 1'b1;
      res_o.is_copy = 1'b0;
      res_o.data    = '0;
      res_o.pos     = wp_q[15:0];
      res_o.status  = fin_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q    <= '0;
      wp_q     <= '0;
      stage_q  <= '0;
      kind_q   <= KIND_NONE;
      hdr_q    <= '0;
      pend_q   <= '0;
      src_q    <= '0;
      fill_q   <= '0;
      halted_q <= 1'b0;
    end else begin
      if (cfg_we_i) exp_q <= cfg_data_i;
      wp_q     <= wp_d;
      stage_q  <= stage_d;
      kind_q   <= kind_d;
      hdr_q    <= hdr_d;
      pend_q   <= pend_d;
      src_q    <= src_d;
      fill_q   <= fill_d;
      halted_q <= halted_d;
    end
  end

endmodule

// File: rtl/lcwf80_out.sv
// Store-write stage with read forwarding and output register.
// Depends on lcwf80_pkg.
module lcwf80_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  lcwf80_pkg::res_t              res_i,
  input  lcwf80_pkg::rd_t               rd_i,
  input  logic [7:0]                    rdata_i,
  output logic                          we_o,
  output logic [lcwf80_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                    wdata_o,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lcwf80_pkg::out_item_t         out_item_o
);
  import lcwf80_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  res_t      s1_q;
  logic      fwd_q, fwd_d;
  logic [7:0] fwd_byte_q;
  logic      s1_adv;
  logic [7:0] s1_byte;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;

  assign s1_byte = s1_q.is_copy ? (fwd_q ? fwd_byte_q : rdata_i) : s1_q.data;

  assign we_o    = s1_adv & (s1_q.status == ST_DATA);
  assign waddr_o = s1_q.pos[ADDR_W-1:0];
  assign wdata_o = s1_byte;

  // read of the entry written in the same cycle
  assign fwd_d = rd_i.en & we_o & (rd_i.addr == waddr_o);

  always_comb begin
    if (accept_i)    s1_valid_d = res_i.valid;
    else if (s1_adv) s1_valid_d = 1'b0;
    else             s1_valid_d = s1_valid_q;
    if (s1_adv)                     out_valid_d = 1'b1;
    else if (!out_stall_i)          out_valid_d = 1'b0;
    else                            out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q       <= res_i;
      fwd_q      <= fwd_d;
      fwd_byte_q <= s1_byte;
    end
    if (s1_adv) begin
      out_q.out_byte <= s1_byte;
      out_q.out_pos  <= s1_q.pos;
      out_q.status   <= s1_q.status;
      out_q.last     <= (s1_q.status != ST_DATA);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/lcw_format80_decompressor_top.sv
// Top level of the LCW format80 decompressor.
// Depends on lcwf80_pkg, lcwf80_ram, lcwf80_ctrl, lcwf80_out.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item per accept,
//   either a compressed byte, a drain tick or a restart.
//   Output channel (out_valid_o / out_stall_i / out_item_o): decoded bytes and
//   the final status item, which carries last.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): expected_total;
//   always ready, write it only while the block is idle.
// Path: a result enters the write stage register when its item is accepted and
//   then the output register; it moves on later while out_stall_i holds.
// Throughput: one item per cycle while in_stall_o is low. Each item does at
//   most one image store read and one write; the read data arrive in the next
//   cycle, and a read of the entry being written in the same cycle is forwarded.
// Reset: all stream state clears at once; the 64K image store is not cleared
//   and needs no clearing pass. expected_total resets to zero.
// Stall: a stalled result holds in the output register while one more result
//   moves into the write stage; with both full, in_stall_o rises.
module lcw_format80_decompressor_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lcwf80_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lcwf80_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [16:0]           cfg_data_i
);
  import lcwf80_pkg::*;

  logic              accept;
  res_t              res;
  rd_t               rd;
  logic [7:0]        rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i & ~in_stall_o;

  lcwf80_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res),
    .rd_o       (rd)
  );

  lcwf80_ram #(
    .AW (ADDR_W),
    .DW (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  lcwf80_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .res_i       (res),
    .rd_i        (rd),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/lcwf80_checker.sv
// Port-level checker for the LCW format80 decompressor, bound to the top level.
// Depends on lcwf80_pkg and lcw_format80_decompressor_top_assert.svh.
`include "lcw_format80_decompressor_top_assert.svh"

module lcwf80_port_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input lcwf80_pkg::out_item_t out_item_o
);
  import lcwf80_pkg::*;

  `LCWF80_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                      out_valid_o, "stalled item dropped")
  `LCWF80_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                      $stable(out_item_o), "stalled item changed")
  `LCWF80_ASSERT_NOW(a_last_status, clk_i, rst_ni,
                     out_valid_o |-> (out_item_o.last == (out_item_o.status != ST_DATA)),
                     "last does not match status")
  `LCWF80_ASSERT_NOW(a_status_byte, clk_i, rst_ni,
                     (out_valid_o && out_item_o.status != ST_DATA) |-> (out_item_o.out_byte == 8'd0),
                     "status item carries a byte")

endmodule

bind lcw_format80_decompressor_top lcwf80_port_checker u_lcwf80_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
